// File: rtl/dclpn_pkg.sv
// ----------------------------------------------------------------------------
// dclpn_pkg
// Shared types and constants of the LED string packet node.
// ----------------------------------------------------------------------------
package dclpn_pkg;

	localparam int unsigned BYTE_W = 8;

	// Byte positions within a frame
	localparam logic [BYTE_W-1:0] POS_COUNT      = 8'd1;
	localparam logic [BYTE_W-1:0] POS_RED        = 8'd2;
	localparam logic [BYTE_W-1:0] POS_GREEN      = 8'd3;
	localparam logic [BYTE_W-1:0] POS_BLUE       = 8'd4;
	localparam logic [BYTE_W-1:0] FIRST_PASS_POS = 8'd5;
	localparam logic [BYTE_W-1:0] POS_MAX        = 8'd255;

	// Duty bytes taken out of the frame by each node
	localparam logic [BYTE_W-1:0] DUTY_BYTES     = 8'd3;

	// Input register contents handed to the relay logic
	typedef struct packed {
		logic              vld;
		logic [BYTE_W-1:0] rx_byte;
	} stage_t;

	// One result transaction
	typedef struct packed {
		logic              send;
		logic [BYTE_W-1:0] tx_byte;
		logic              frame_end;
		logic [BYTE_W-1:0] red_duty;
		logic [BYTE_W-1:0] green_duty;
		logic [BYTE_W-1:0] blue_duty;
	} result_t;

endpackage

// File: rtl/dclpn_in_if.sv
// ----------------------------------------------------------------------------
// dclpn_in_if
// Received-byte channel: valid/ready handshake with one byte of payload.
// ----------------------------------------------------------------------------
interface dclpn_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: rtl/dclpn_out_if.sv
// ----------------------------------------------------------------------------
// dclpn_out_if
// Result channel: valid/ready handshake carrying the forwarded byte,
// the frame-end flag and the applied duties.
// ----------------------------------------------------------------------------
interface dclpn_out_if;
	logic       valid;
	logic       ready;
	logic       send;
	logic [7:0] tx_byte;
	logic       frame_end;
	logic [7:0] red_duty;
	logic [7:0] green_duty;
	logic [7:0] blue_duty;

	modport source (output valid, output send, output tx_byte, output frame_end,
		output red_duty, output green_duty, output blue_duty, input ready);
	modport sink   (input valid, input send, input tx_byte, input frame_end,
		input red_duty, input green_duty, input blue_duty, output ready);
endinterface

// File: rtl/daisy_chain_led_packet_node_core.sv
// ----------------------------------------------------------------------------
// daisy_chain_led_packet_node_core
// Packet relay node of a daisy-chained RGB LED string.
// ----------------------------------------------------------------------------
// Every received byte gives exactly one result transaction. The node accepts
// one byte per clock cycle sustained while the result channel is ready; a
// byte passes through the input register and then the result register,
// with the frame-tracking logic between them. The first byte of a frame is
// forwarded as the count minus three, bytes two to four are stored as
// pending red, green and blue duties (send low, tx_byte zero), and later
// bytes pass unchanged. On the byte whose position equals the count,
// frame_end rises and the pending duties are applied; the duties on each
// result are the values after that byte. A count of zero never ends a
// frame. Backpressure on the result channel stalls both registers.
// ----------------------------------------------------------------------------
module daisy_chain_led_packet_node_core (
	input  logic        clk,
	input  logic        arst_n,
	dclpn_in_if.sink    upstream,
	dclpn_out_if.source downstream
);

	dclpn_pkg::stage_t  stage;
	dclpn_pkg::result_t result;
	dclpn_pkg::result_t result_q;
	logic               out_vld_q;
	logic               advance;

	// Move the held byte when the result register is free or draining
	assign advance = stage.vld && (!out_vld_q || downstream.ready);

	dclpn_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.upstream (upstream),
		.advance  (advance),
		.stage    (stage)
	);

	dclpn_relay u_relay (
		.clk     (clk),
		.arst_n  (arst_n),
		.stage   (stage),
		.advance (advance),
		.result  (result)
	);

	// Result register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance) begin
			out_vld_q <= 1'b1;
		end else if (downstream.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign downstream.valid      = out_vld_q;
	assign downstream.send       = result_q.send;
	assign downstream.tx_byte    = result_q.tx_byte;
	assign downstream.frame_end  = result_q.frame_end;
	assign downstream.red_duty   = result_q.red_duty;
	assign downstream.green_duty = result_q.green_duty;
	assign downstream.blue_duty  = result_q.blue_duty;

endmodule

// File: rtl/dclpn_in_stage.sv
// ----------------------------------------------------------------------------
// dclpn_in_stage
// Input register: captures one received byte per transaction and holds it
// until the relay logic consumes it.
// ----------------------------------------------------------------------------
module dclpn_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	dclpn_in_if.sink          upstream,
	input  logic              advance,
	output dclpn_pkg::stage_t stage
);

	logic                          vld_s1;
	logic [dclpn_pkg::BYTE_W-1:0]  rx_byte_s1;
	logic                          load;

	// Accept when empty or when the held byte moves on this cycle
	assign upstream.ready = !vld_s1 || advance;
	assign load           = upstream.valid && upstream.ready;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (load) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	// Capture payload
	always_ff @(posedge clk) begin
		if (load) begin
			rx_byte_s1 <= upstream.rx_byte;
		end
	end

	assign stage.vld     = vld_s1;
	assign stage.rx_byte = rx_byte_s1;

endmodule

// File: rtl/dclpn_relay.sv
// ----------------------------------------------------------------------------
// dclpn_relay
// Frame tracking: position counter, stored count, pending and applied
// duties, and the per-byte forward decision.
// ----------------------------------------------------------------------------
module dclpn_relay (
	input  logic               clk,
	input  logic               arst_n,
	input  dclpn_pkg::stage_t  stage,
	input  logic               advance,
	output dclpn_pkg::result_t result
);

	logic [dclpn_pkg::BYTE_W-1:0] pos_q;
	logic [dclpn_pkg::BYTE_W-1:0] total_q;
	logic [dclpn_pkg::BYTE_W-1:0] pend_red_q, pend_green_q, pend_blue_q;
	logic [dclpn_pkg::BYTE_W-1:0] app_red_q, app_green_q, app_blue_q;

	logic [dclpn_pkg::BYTE_W-1:0] pos_d;
	logic [dclpn_pkg::BYTE_W-1:0] total_d;
	logic [dclpn_pkg::BYTE_W-1:0] pend_red_d, pend_green_d, pend_blue_d;
	logic [dclpn_pkg::BYTE_W-1:0] app_red_d, app_green_d, app_blue_d;
	logic                         send;
	logic [dclpn_pkg::BYTE_W-1:0] tx_byte;
	logic                         fend;

	// Decode the byte's place in the frame
	always_comb begin
		total_d      = total_q;
		pend_red_d   = pend_red_q;
		pend_green_d = pend_green_q;
		pend_blue_d  = pend_blue_q;
		send         = 1'b1;
		tx_byte      = stage.rx_byte;
		unique case (pos_q)
			dclpn_pkg::POS_COUNT: begin
				total_d = stage.rx_byte;
				tx_byte = stage.rx_byte - dclpn_pkg::DUTY_BYTES;
			end
			dclpn_pkg::POS_RED: begin
				pend_red_d = stage.rx_byte;
				send       = 1'b0;
				tx_byte    = '0;
			end
			dclpn_pkg::POS_GREEN: begin
				pend_green_d = stage.rx_byte;
				send         = 1'b0;
				tx_byte      = '0;
			end
			dclpn_pkg::POS_BLUE: begin
				pend_blue_d = stage.rx_byte;
				send        = 1'b0;
				tx_byte     = '0;
			end
			default: begin
				send    = 1'b1;
				tx_byte = stage.rx_byte;
			end
		endcase
	end

	// End the frame when the position reaches the count; else advance and saturate
	always_comb begin
		fend        = (pos_q == total_d);
		app_red_d   = app_red_q;
		app_green_d = app_green_q;
		app_blue_d  = app_blue_q;
		if (fend) begin
			app_red_d   = pend_red_d;
			app_green_d = pend_green_d;
			app_blue_d  = pend_blue_d;
			pos_d       = dclpn_pkg::POS_COUNT;
		end else if (pos_q != dclpn_pkg::POS_MAX) begin
			pos_d = pos_q + 8'd1;
		end else begin
			pos_d = pos_q;
		end
	end

	// Commit state when the byte moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= dclpn_pkg::POS_COUNT;
			total_q      <= '0;
			pend_red_q   <= '0;
			pend_green_q <= '0;
			pend_blue_q  <= '0;
			app_red_q    <= '0;
			app_green_q  <= '0;
			app_blue_q   <= '0;
		end else if (advance) begin
			pos_q        <= pos_d;
			total_q      <= total_d;
			pend_red_q   <= pend_red_d;
			pend_green_q <= pend_green_d;
			pend_blue_q  <= pend_blue_d;
			app_red_q    <= app_red_d;
			app_green_q  <= app_green_d;
			app_blue_q   <= app_blue_d;
		end
	end

	assign result.send       = send;
	assign result.tx_byte    = tx_byte;
	assign result.frame_end  = fend;
	assign result.red_duty   = app_red_d;
	assign result.green_duty = app_green_d;
	assign result.blue_duty  = app_blue_d;

`ifndef ASSERT_OFF
	a_pos_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q != '0)
		else $error("position counter reached zero");

	a_end_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		advance && fend |=> pos_q == dclpn_pkg::POS_COUNT)
		else $error("frame end did not restart the position");

	a_duties_hold: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !fend |=> $stable(app_red_q) && $stable(app_green_q)
			&& $stable(app_blue_q))
		else $error("applied duties changed without a frame end");

	a_quiet_tx: assert property (@(posedge clk) disable iff (!arst_n)
		!send |-> tx_byte == '0 && pos_q != dclpn_pkg::POS_COUNT)
		else $error("duty byte leaked downstream");
`endif

endmodule
